/* rtl/swts_pkg.sv */
`default_nettype none

package swts_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 9;
  localparam int HELD_W   = 9;
  localparam int SLOPE_W  = 49;
  localparam int FRAC_W   = 16;

  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(256);

  // running sums over the window
  localparam int SY_W  = SAMPLE_W + PTR_W;
  localparam int SXY_W = SAMPLE_W + 2 * PTR_W;

  // shared multiplier: narrow operand holds n*n, wide operand holds the sums
  localparam int MUL_A_W = 2 * CNT_W - 1;
  localparam int MUL_B_W = SXY_W;
  localparam int MUL_W   = MUL_A_W + MUL_B_W;

  // divider: (12 * |n*Sxy - Sx*Sy|) << FRAC_W over n*n*(n*n - 1)
  localparam int DEN_W  = 2 * MUL_A_W;
  localparam int DVD_W  = MUL_W + 4 + FRAC_W;
  localparam int STEP_W = $clog2(DVD_W + 1);

  localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SLOPE_W + HELD_W + 7) / 8) * 8;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_status_t;

endpackage

`default_nettype wire

/* rtl/sliding_window_trend_slope_core.sv */
// Sliding-window least-squares trend slope.
// in_*  : one 32-bit unsigned sample per transaction, appended to a window
//         of the most recent samples (oldest has index 0).
// out_* : one transaction per sample: trend_slope (signed, 16 fraction
//         bits, truncated toward zero, saturated to 49 bits) and
//         samples_held after the insertion.
// cfg_* : window length, written when cfg_wr_en is high; 0 acts as 1,
//         values above 256 act as 256. Takes effect at the next sample,
//         which then drops oldest samples until the window fits.
// Timing: a sample runs through a small sequencer that drops old samples
//   (a RAM read state and a subtract state for each), updates the running
//   sums, forms the products on one shared 17x48 multiplier and then divides
//   on a bit-serial divider of 85 steps. A new sample is accepted only once
//   the previous result has gone to the output register; a single-sample
//   window skips the division.
//   in_tready is high only while no sample is in work.
// Stall: the result sits in the output register until out_tready; a new
//   sample may be accepted meanwhile, and its result waits for the slot.
// Reset: the window is emptied, sums cleared, window length set to 256.
`default_nettype none

module sliding_window_trend_slope_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [swts_pkg::CFG_W-1:0]         cfg_wr_data,      // window_length
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [swts_pkg::IN_DATA_W-1:0]     in_tdata,         // sample_value
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [swts_pkg::OUT_DATA_W-1:0]    out_tdata         // trend_slope, samples_held
);

  localparam int PTR_W    = swts_pkg::PTR_W;
  localparam int CNT_W    = swts_pkg::CNT_W;
  localparam int SAMPLE_W = swts_pkg::SAMPLE_W;
  localparam int CFG_W    = swts_pkg::CFG_W;
  localparam int HELD_W   = swts_pkg::HELD_W;
  localparam int SLOPE_W  = swts_pkg::SLOPE_W;
  localparam int FRAC_W   = swts_pkg::FRAC_W;
  localparam int SY_W     = swts_pkg::SY_W;
  localparam int SXY_W    = swts_pkg::SXY_W;
  localparam int MUL_A_W  = swts_pkg::MUL_A_W;
  localparam int MUL_B_W  = swts_pkg::MUL_B_W;
  localparam int MUL_W    = swts_pkg::MUL_W;
  localparam int DEN_W    = swts_pkg::DEN_W;
  localparam int DVD_W    = swts_pkg::DVD_W;
  localparam int OUT_W    = swts_pkg::OUT_DATA_W;

  localparam logic [SLOPE_W-1:0] POS_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] NEG_MAG = {1'b1, {(SLOPE_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_DROP_RD,
    S_DROP_SUB,
    S_APPEND,
    S_ACC,
    S_MUL_P,
    S_MUL_SX,
    S_MUL_Q,
    S_MUL_N2,
    S_MUL_D,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  state_t             state_r;
  logic [CFG_W-1:0]   cfg_len_r;
  logic [CNT_W-1:0]   fill_r;
  logic [PTR_W-1:0]   oldest_r;
  logic [SY_W-1:0]    sy_r;
  logic [SXY_W-1:0]   sxy_r;
  logic               out_tvalid_r;
  logic [OUT_W-1:0]   out_tdata_r;

  logic [SAMPLE_W-1:0] y_r;
  logic [CNT_W-1:0]    len_r;
  logic [MUL_W-1:0]    mul_r;
  logic [MUL_W-1:0]    p_r;
  logic [MUL_W-1:0]    q_r;
  logic [MUL_W-1:0]    mag_r;
  logic                neg_r;
  logic [SLOPE_W-1:0]  slope_r;

  logic [CNT_W-1:0]    len_eff;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic                ram_wr_en;
  logic                ram_rd_en;
  logic [PTR_W-1:0]    ram_wr_addr;
  logic [SAMPLE_W-1:0] ram_rd_data;
  logic [SY_W-1:0]     sy_drop;
  logic [MUL_W+3:0]    mag12;
  logic                div_start;
  logic [DVD_W-1:0]    div_dividend;
  logic [SLOPE_W-1:0]  div_quo;
  swts_pkg::div_status_t div_st;
  logic [SLOPE_W-1:0]  mag_sat;
  logic [SLOPE_W-1:0]  slope_sat;

  always_comb begin
    if (cfg_len_r == '0) begin
      len_eff = CNT_W'(1);
    end else if (int'(cfg_len_r) > swts_pkg::MAX_WINDOW) begin
      len_eff = CNT_W'(swts_pkg::MAX_WINDOW);
    end else begin
      len_eff = CNT_W'(cfg_len_r);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_APPEND: begin
        mul_a = MUL_A_W'(fill_r);
        mul_b = MUL_B_W'(y_r);
      end
      S_MUL_P: begin
        mul_a = MUL_A_W'(fill_r);
        mul_b = MUL_B_W'(sxy_r);
      end
      S_MUL_SX: begin
        mul_a = MUL_A_W'(fill_r);
        mul_b = MUL_B_W'(fill_r - CNT_W'(1));
      end
      S_MUL_Q: begin
        mul_a = mul_r[MUL_A_W:1];
        mul_b = MUL_B_W'(sy_r);
      end
      S_MUL_N2: begin
        mul_a = MUL_A_W'(fill_r);
        mul_b = MUL_B_W'(fill_r);
      end
      S_MUL_D: begin
        mul_a = mul_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(mul_r[MUL_A_W-1:0] - MUL_A_W'(1));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign ram_rd_en   = (state_r == S_DROP_RD) && (fill_r >= len_r);
  assign ram_wr_en   = (state_r == S_APPEND);
  assign ram_wr_addr = oldest_r + fill_r[PTR_W-1:0];
  assign sy_drop     = sy_r - SY_W'(ram_rd_data);

  assign mag12        = {1'b0, mag_r, 3'b000} + {2'b00, mag_r, 2'b00};
  assign div_dividend = {mag12, {FRAC_W{1'b0}}};
  assign div_start    = (state_r == S_DIV_GO);

  always_comb begin
    if (neg_r) begin
      mag_sat   = (div_st.ovf || (div_quo > NEG_MAG)) ? NEG_MAG : div_quo;
      slope_sat = '0 - mag_sat;
    end else begin
      mag_sat   = (div_st.ovf || (div_quo > POS_MAX)) ? POS_MAX : div_quo;
      slope_sat = mag_sat;
    end
  end

  swts_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (swts_pkg::MAX_WINDOW)
  ) u_window (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (y_r),
    .rd_en   (ram_rd_en),
    .rd_addr (oldest_r),
    .rd_data (ram_rd_data)
  );

  swts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (mul_r[DEN_W-1:0]),
    .quotient (div_quo),
    .status   (div_st)
  );

  // sequencer, window bookkeeping and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_len_r    <= swts_pkg::LEN_RESET;
      fill_r       <= '0;
      oldest_r     <= '0;
      sy_r         <= '0;
      sxy_r        <= '0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
      if ((state_r == S_OUT) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= OUT_W'({HELD_W'(fill_r), slope_r});
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_DROP_RD;
          end
        end
        S_DROP_RD: begin
          state_r <= (fill_r >= len_r) ? S_DROP_SUB : S_APPEND;
        end
        S_DROP_SUB: begin
          sy_r     <= sy_drop;
          sxy_r    <= sxy_r - SXY_W'(sy_drop);
          oldest_r <= oldest_r + PTR_W'(1);
          fill_r   <= fill_r - CNT_W'(1);
          state_r  <= S_DROP_RD;
        end
        S_APPEND: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          sxy_r   <= sxy_r + mul_r[SXY_W-1:0];
          sy_r    <= sy_r + SY_W'(y_r);
          fill_r  <= fill_r + CNT_W'(1);
          state_r <= (fill_r == '0) ? S_OUT : S_MUL_P;
        end
        S_MUL_P:  state_r <= S_MUL_SX;
        S_MUL_SX: state_r <= S_MUL_Q;
        S_MUL_Q:  state_r <= S_MUL_N2;
        S_MUL_N2: state_r <= S_MUL_D;
        S_MUL_D:  state_r <= S_DIV_GO;
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_st.done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        y_r   <= in_tdata[SAMPLE_W-1:0];
        len_r <= len_eff;
      end
      S_ACC: begin
        slope_r <= '0;
      end
      S_MUL_SX: begin
        p_r <= mul_r;
      end
      S_MUL_D: begin
        neg_r <= (p_r < q_r);
        mag_r <= (p_r < q_r) ? (q_r - p_r) : (p_r - q_r);
      end
      S_MUL_N2: begin
        q_r <= mul_r;
      end
      S_DIV_WAIT: begin
        slope_r <= slope_sat;
      end
      default: begin
      end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_slope_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && slope_r != '0) |-> (fill_r >= CNT_W'(2)))
    else $error("nonzero slope with fewer than two samples");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPEND) |-> (fill_r < len_r))
    else $error("append into a full window");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIV_WAIT))
    else $error("divider finished outside wait state");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_OUT))
    else $error("result raised without sequencer");

endmodule

`default_nettype wire

/* rtl/swts_ram.sv */
`default_nettype none

module swts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/swts_div.sv */
`default_nettype none

module swts_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [swts_pkg::DVD_W-1:0]   dividend,
  input  wire logic [swts_pkg::DEN_W-1:0]   divisor,
  output logic      [swts_pkg::SLOPE_W-1:0] quotient,
  output swts_pkg::div_status_t             status
);

  localparam int DVD_W   = swts_pkg::DVD_W;
  localparam int DEN_W   = swts_pkg::DEN_W;
  localparam int SLOPE_W = swts_pkg::SLOPE_W;
  localparam int STEP_W  = swts_pkg::STEP_W;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [SLOPE_W-1:0] quo_r;
  logic              ovf_r;

  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   diff;
  logic [DEN_W-1:0] rem_nxt;

  // one restoring step per cycle
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    fits    = (trial >= {1'b0, den_r});
    diff    = trial - {1'b0, den_r};
    rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[SLOPE_W-2:0], fits};
      ovf_r <= ovf_r | quo_r[SLOPE_W-1];
    end
  end

  assign quotient    = quo_r;
  assign status.done = done_r;
  assign status.ovf  = ovf_r;

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import swts_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 150;
  localparam int ITEM_TARGET = 1400;

  typedef struct packed {
    logic [HELD_W-1:0]  held;
    logic [SLOPE_W-1:0] slope;
  } trend_result_t;

  class slope_scoreboard;
    logic [SAMPLE_W-1:0] window_store[MAX_WINDOW];
    int unsigned         oldest;
    int unsigned         fill;
    logic [CFG_W-1:0]    length_reg;
    trend_result_t       expected_slopes[$];
    int unsigned         mismatches;
    int unsigned         results_checked;

    function void clear();
      oldest = 0;
      fill = 0;
      length_reg = LEN_RESET;
      expected_slopes.delete();
      mismatches = 0;
      results_checked = 0;
    endfunction

    function void set_length(logic [CFG_W-1:0] v);
      length_reg = v;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] v);
      int unsigned   span;
      int unsigned   drop;
      int unsigned   i;
      logic [63:0]   sy;
      logic [63:0]   sxy;
      logic [63:0]   n;
      logic [63:0]   sx;
      logic [63:0]   den;
      logic [127:0]  p;
      logic [127:0]  q;
      logic [127:0]  quo;
      logic          neg;
      trend_result_t r;
      span = length_reg;
      if (span < 1) span = 1;
      if (span > MAX_WINDOW) span = MAX_WINDOW;
      if (fill >= span) begin
        drop = fill - span + 1;
        oldest = (oldest + drop) % MAX_WINDOW;
        fill -= drop;
      end
      window_store[(oldest + fill) % MAX_WINDOW] = v;
      fill++;
      sy = '0;
      sxy = '0;
      for (i = 0; i < fill; i++) begin
        sy += window_store[(oldest + i) % MAX_WINDOW];
        sxy += 64'(i) * window_store[(oldest + i) % MAX_WINDOW];
      end
      r.slope = '0;
      if (fill >= 2) begin
        n = fill;
        sx = n * (n - 1) / 2;
        den = n * n * (n * n - 1) / 12;
        p = 128'(n) * 128'(sxy);
        q = 128'(sx) * 128'(sy);
        neg = p < q;
        quo = ((neg ? q - p : p - q) << FRAC_W) / 128'(den);
        if (neg) begin
          if (quo > (128'd1 << (SLOPE_W - 1))) quo = 128'd1 << (SLOPE_W - 1);
          quo = -quo;
        end else if (quo >= (128'd1 << (SLOPE_W - 1))) begin
          quo = (128'd1 << (SLOPE_W - 1)) - 1;
        end
        r.slope = quo[SLOPE_W-1:0];
      end
      r.held = HELD_W'(fill);
      expected_slopes = {expected_slopes, r};
    endfunction

    function void check_result(trend_result_t got);
      trend_result_t want;
      if (expected_slopes.size() == 0) begin
        $error("result with no sample pending: trend_slope %0d, samples_held %0d",
               $signed(got.slope), got.held);
        mismatches++;
        return;
      end
      want = expected_slopes.pop_front();
      results_checked++;
      if (got.slope !== want.slope) begin
        $error("trend_slope mismatch: expected %0d, actual %0d",
               $signed(want.slope), $signed(got.slope));
        mismatches++;
      end
      if (got.held !== want.held) begin
        $error("samples_held mismatch: expected %0d, actual %0d", want.held, got.held);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // sample_value
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // trend_slope, samples_held

  slope_scoreboard sb;
  logic            quiet_gaps = 1'b0;
  logic            hold_off_req = 1'b0;
  int unsigned     samples_sent = 0;
  int unsigned     length_writes = 0;
  int unsigned     idle_cycles = 0;
  logic [31:0]     ramp_base = '0;
  logic [31:0]     ramp_step = '0;

  sliding_window_trend_slope_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stalled for %0d cycles with no transaction", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(trend_result_t'(out_tdata[SLOPE_W+HELD_W-1:0]));
    end
  end

  initial begin : receiver
    int unsigned gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = quiet_gaps ? 0 : $urandom_range(17);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  function automatic logic [SAMPLE_W-1:0] draw_sample(int unsigned k);
    case ($urandom_range(9))
      0: return '1;
      1: return '0;
      2: return SAMPLE_W'($urandom_range(255));
      3, 4, 5, 6: return ramp_base + ramp_step * k + SAMPLE_W'($urandom_range(63));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    int unsigned gap;
    gap = quiet_gaps ? 0 : $urandom_range(17);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_sample(v);
    samples_sent++;
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    in_tvalid <= 1'b0;
    while (sb.expected_slopes.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_length(v);
    length_writes++;
  endtask

  initial begin : stimulus
    int unsigned      span;
    int unsigned      items;
    int unsigned      k;
    logic [CFG_W-1:0] len;
    sb = new();
    sb.clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length, first pair at both extremes
    send_sample('0);
    send_sample('1);
    send_sample('0);
    // zero length acts as one, shrinking a held window
    write_length(CFG_W'(0));
    send_sample('1);
    send_sample(32'h1234_5678);
    // two-sample window, steepest rise and fall
    write_length(CFG_W'(2));
    send_sample('0);
    send_sample('1);
    send_sample('0);
    // oversized length acts as the maximum
    write_length('1);
    for (k = 1; k <= 5; k++) send_sample(32'(k * 100));
    write_length(CFG_W'(3));
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    write_length(CFG_W'(257));
    send_sample(32'hDEAD_BEEF);
    send_sample(32'h0000_0001);
    send_sample(32'hFFFF_FFFE);
    write_length(CFG_W'(1));
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);

    // full window with wrap, receiver held off while the sender keeps pushing
    write_length(CFG_W'(MAX_WINDOW));
    ramp_base = $urandom();
    ramp_step = 32'($urandom_range(2000)) - 32'd1000;
    quiet_gaps = 1'b1;
    hold_off_req = 1'b1;
    for (k = 0; k < 300; k++) begin
      if (k == 40) quiet_gaps = 1'b0;
      send_sample(draw_sample(k));
    end

    while (samples_sent < ITEM_TARGET) begin
      case ($urandom_range(11))
        0: len = '0;
        1: len = CFG_W'(1);
        2: len = CFG_W'(2);
        3: len = CFG_W'(MAX_WINDOW);
        4: len = '1;
        5: len = CFG_W'($urandom_range(511, 257));
        6, 7, 8: len = CFG_W'($urandom_range(20, 3));
        default: len = CFG_W'($urandom_range(511, 1));
      endcase
      span = (len == 0) ? 1 : ((len > MAX_WINDOW) ? MAX_WINDOW : len);
      items = (span >= 64) ? $urandom_range(span + 20, 20) : $urandom_range(60, 5);
      if ($urandom_range(5) != 0) write_length(len);
      quiet_gaps = ($urandom_range(4) == 0);
      ramp_base = $urandom();
      ramp_step = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(2000)) - 32'd1000;
      for (k = 0; k < items && samples_sent < ITEM_TARGET; k++) send_sample(draw_sample(k));
    end

    in_tvalid <= 1'b0;
    while (sb.expected_slopes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d slope results over %0d samples", sb.results_checked, samples_sent);
    $display("window length set %0d times, covering 0, 1, 2, 256 and above 256",
             length_writes);
    if (sb.mismatches == 0 && sb.expected_slopes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
